FILE: hdl/spsa_pkg.sv
// ----------------------------------------------------------------------------
// Servo axis stabiliser package
// Widths, register indexes, reset values and sequencer states shared by the
// stabiliser core.
// ----------------------------------------------------------------------------
package spsa_pkg;

	// field widths
	localparam int STICK_W = 16;
	localparam int RATE_W  = 32;
	localparam int GAIN_W  = 24;
	localparam int MAXT_W  = 31;
	localparam int MODE_W  = 3;
	localparam int CFG_W   = 31;
	localparam int IDX_W   = 3;

	// input and output words
	localparam int S_DATA_W = STICK_W + 2 * RATE_W;
	localparam int M_DATA_W = STICK_W;

	// datapath widths
	localparam int OFS_W    = STICK_W + 1;
	localparam int ERR_W    = RATE_W;
	localparam int DELTA_W  = RATE_W + 1;
	localparam int INTEG_W  = 48;
	localparam int INTEG_H  = INTEG_W / 2;
	localparam int MUL_A_W  = 33;
	localparam int MUL_B_W  = GAIN_W + 1;
	localparam int PROD_W   = MUL_A_W + MUL_B_W;
	localparam int ACC_W    = 73;
	localparam int SUM_SH   = 40;
	localparam int SUM_W    = SUM_SH + 2;
	localparam int FRAC_W   = 32;
	localparam int SCALED_W = SUM_W + 10;
	localparam int ADJ_W    = SCALED_W - FRAC_W;
	localparam int SERVO_W  = ADJ_W + 2;
	localparam int DIV_W    = 48;
	localparam int DIV_STEPS = DIV_W;
	localparam int CNT_W    = $clog2(DIV_STEPS);
	localparam int TGT_W    = DIV_W + 1;
	localparam int DIFF_W   = TGT_W + 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER   = 3'd3;
	localparam logic [IDX_W-1:0] REG_LIM_LO   = 3'd4;
	localparam logic [IDX_W-1:0] REG_LIM_HI   = 3'd5;
	localparam logic [IDX_W-1:0] REG_MAX_TGT  = 3'd6;
	localparam logic [IDX_W-1:0] REG_MODE     = 3'd7;

	// mode bits
	localparam int MODE_EN  = 0;
	localparam int MODE_RATE = 1;
	localparam int MODE_REV = 2;

	// register reset values
	localparam logic [STICK_W-1:0] CENTER_RST = 16'd4500;
	localparam logic [STICK_W-1:0] LIM_LO_RST = 16'd3000;
	localparam logic [STICK_W-1:0] LIM_HI_RST = 16'd6000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_TGT,
		ST_DIV_LOAD,
		ST_DIV,
		ST_TGT,
		ST_ERR,
		ST_MUL_P,
		ST_MUL_D,
		ST_MUL_IL,
		ST_MUL_IH,
		ST_SUM,
		ST_CLIP,
		ST_SCALE,
		ST_ADJ,
		ST_DONE
	} st_t;

endpackage

FILE: hdl/servo_pid_stabilizer_axis_core.sv
// ----------------------------------------------------------------------------
// Servo axis PID stabiliser core
// Incremental PID with anti-windup for one servo axis, built round one shared
// multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis_*): one word per control update, carrying the stick
//   pulse, the gyro rate and the averaged gyro rate. Output stream (m_axis_*):
//   one word per update with the servo pulse in tdata and the clamp flag in
//   tuser. Configuration (cfg_*): register index and data, always ready;
//   write only while no update is in flight.
// Sequence: a disabled axis goes straight from idle to the final state;
//   rate-only mode runs the error, product, sum, clip, scale and adjust
//   states, and auto mode first runs a 48-step restoring divider that turns
//   stick deflection into a target rate. The four gain products share one
//   multiplier, one product per cycle. s_axis_tready is high only while the
//   sequencer is idle, so a new item waits until the last has left it.
// Stall: the result sits in an output register; the core moves on to the next
//   item once the register is free or being emptied. A stalled receiver
//   holds the sequencer in its final state with the word pending.
// Reset: arst_n clears the PID state, the output register and the sequencer,
//   and loads the registers with their reset values.
// ----------------------------------------------------------------------------
module servo_pid_stabilizer_axis_core
	import spsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// stick_in [15:0], measured_rate [47:16], averaged_rate [79:48]
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// servo_out [15:0]
	output logic [M_DATA_W-1:0] m_axis_tdata,
	// was_clamped [0]
	output logic                m_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	// bounds used by the saturations
	localparam logic signed [ACC_W-1:0] SUM_HI =
		{{(ACC_W-SUM_SH-1){1'b0}}, 1'b1, {SUM_SH{1'b0}}};
	localparam logic signed [ACC_W-1:0] SUM_LO = -SUM_HI;
	localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
	localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam logic signed [ADJ_W-1:0] ADJ16_MAX = 20'sd32767;
	localparam logic signed [ADJ_W-1:0] ADJ16_MIN = -20'sd32768;

	// configuration registers
	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic        [STICK_W-1:0] center_q, lim_lo_q, lim_hi_q;
	logic        [MAXT_W-1:0]  max_tgt_q;
	logic        [MODE_W-1:0]  mode_q;

	// PID state
	logic signed [ERR_W-1:0]   prev_err_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic        [STICK_W-1:0] prev_servo_q;

	// item registers
	logic        [STICK_W-1:0] stick_q;
	logic signed [RATE_W-1:0]  rate_q, avg_q;
	logic signed [OFS_W-1:0]   offset_q, span_q;

	// working registers
	st_t                        state_q, state_d;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic        [DIV_W-1:0]    num_q;
	logic        [STICK_W-1:0]  rem_q, dsor_q;
	logic                       neg_q;
	logic        [CNT_W-1:0]    cnt_q;
	logic signed [TGT_W-1:0]    tgt_q;
	logic signed [ERR_W-1:0]    err_q;
	logic signed [DELTA_W-1:0]  delta_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SCALED_W-1:0] scaled_q;
	logic signed [ADJ_W-1:0]    adj_q;

	// output register
	logic                       out_valid_q;
	logic        [STICK_W-1:0]  servo_q;
	logic                       clamped_q;

	// control
	logic in_acc, out_free, out_load;

	// combinational datapath
	logic signed [OFS_W-1:0]    offset_c, span_c;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [PROD_W-1:0]   prod_mag;
	logic        [STICK_W:0]    div_shift, div_diff;
	logic                       div_ge;
	logic signed [DIFF_W-1:0]   diff_c;
	logic signed [ERR_W-1:0]    err_c;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    sum_clip;
	logic signed [SCALED_W-1:0] sum_ext;
	logic signed [ADJ_W-1:0]    q_rate, q_rate_k;
	logic signed [ADJ_W-1:0]    t_auto, adj_c;
	logic        [STICK_W-1:0]  base_c;
	logic signed [SERVO_W-1:0]  servo_c, lo_c, hi_c;
	logic        [STICK_W-1:0]  servo_sel;
	logic                       clamp_c;
	logic signed [INTEG_W:0]    integ_sum;
	logic signed [INTEG_W-1:0]  integ_c;

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = servo_q;
	assign m_axis_tuser  = clamped_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q  <= '0;
			gain_i_q  <= '0;
			gain_d_q  <= '0;
			center_q  <= CENTER_RST;
			lim_lo_q  <= LIM_LO_RST;
			lim_hi_q  <= LIM_HI_RST;
			max_tgt_q <= '0;
			mode_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P:  gain_p_q  <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:  gain_i_q  <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:  gain_d_q  <= cfg_data[GAIN_W-1:0];
				REG_CENTER:  center_q  <= cfg_data[STICK_W-1:0];
				REG_LIM_LO:  lim_lo_q  <= cfg_data[STICK_W-1:0];
				REG_LIM_HI:  lim_hi_q  <= cfg_data[STICK_W-1:0];
				REG_MAX_TGT: max_tgt_q <= cfg_data[MAXT_W-1:0];
				REG_MODE:    mode_q    <= cfg_data[MODE_W-1:0];
				default:     mode_q    <= mode_q;
			endcase
		end
	end

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					priority if (!s_axis_tdata_en()) state_d = ST_DONE;
					else if (mode_q[MODE_RATE]) state_d = ST_ERR;
					else state_d = ST_MUL_TGT;
				end
			end
			ST_MUL_TGT:  state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = (span_q == '0) ? ST_ERR : ST_DIV;
			ST_DIV:      state_d = (cnt_q == CNT_W'(DIV_STEPS - 1)) ? ST_TGT : ST_DIV;
			ST_TGT:      state_d = ST_ERR;
			ST_ERR:      state_d = ST_MUL_P;
			ST_MUL_P:    state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_MUL_IL;
			ST_MUL_IL:   state_d = ST_MUL_IH;
			ST_MUL_IH:   state_d = ST_SUM;
			ST_SUM:      state_d = ST_CLIP;
			ST_CLIP:     state_d = ST_SCALE;
			ST_SCALE:    state_d = ST_ADJ;
			ST_ADJ:      state_d = ST_DONE;
			ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// the enable bit only ever comes from the mode register
	function automatic logic s_axis_tdata_en();
		return mode_q[MODE_EN];
	endfunction

	// handshake outputs of the sequencer
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		out_free      = !out_valid_q || m_axis_tready;
		out_load      = (state_q == ST_DONE) && out_free;
		in_acc        = s_axis_tvalid && s_axis_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// ---------------------------------------------------------------- datapath
	// stick offset and the span on its side of centre
	always_comb begin
		offset_c = $signed({1'b0, s_axis_tdata[STICK_W-1:0]}) - $signed({1'b0, center_q});
		if (offset_c[OFS_W-1]) span_c = $signed({1'b0, center_q}) - $signed({1'b0, lim_lo_q});
		else span_c = $signed({1'b0, lim_hi_q}) - $signed({1'b0, center_q});
	end

	// shared multiplier: operand choice follows the sequencer
	always_comb begin
		unique case (state_q)
			ST_MUL_TGT: begin
				mul_a = $signed({{(MUL_A_W-MAXT_W){1'b0}}, max_tgt_q});
				mul_b = MUL_B_W'(offset_q);
			end
			ST_MUL_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(gain_p_q);
			end
			ST_MUL_D: begin
				mul_a = MUL_A_W'(delta_q);
				mul_b = MUL_B_W'(gain_d_q);
			end
			ST_MUL_IL: begin
				mul_a = $signed({{(MUL_A_W-INTEG_H){1'b0}}, integ_q[INTEG_H-1:0]});
				mul_b = MUL_B_W'(gain_i_q);
			end
			ST_MUL_IH: begin
				mul_a = MUL_A_W'($signed(integ_q[INTEG_W-1:INTEG_H]));
				mul_b = MUL_B_W'(gain_i_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// divider step and target / error arithmetic
	always_comb begin
		prod_mag  = prod_q[PROD_W-1] ? -prod_q : prod_q;
		div_shift = {rem_q, num_q[DIV_W-1]};
		div_ge    = (div_shift >= {1'b0, dsor_q});
		div_diff  = div_shift - {1'b0, dsor_q};

		if (mode_q[MODE_RATE]) diff_c = DIFF_W'(avg_q) - DIFF_W'(rate_q);
		else diff_c = DIFF_W'(tgt_q) - DIFF_W'(rate_q);
		priority if (diff_c > DIFF_W'(ERR_MAX)) err_c = ERR_MAX;
		else if (diff_c < DIFF_W'(ERR_MIN)) err_c = ERR_MIN;
		else err_c = diff_c[ERR_W-1:0];

		prod_ext = ACC_W'(prod_q);
		priority if (acc_q > SUM_HI) sum_clip = SUM_HI;
		else if (acc_q < SUM_LO) sum_clip = SUM_LO;
		else sum_clip = acc_q;
	end

	// output scaling: sum times 1000 by shift and subtract
	always_comb begin
		sum_ext  = SCALED_W'(sum_q);
		// rate-only: integer part of the sum, truncated toward zero
		q_rate   = ADJ_W'($signed(sum_q[SUM_W-1:FRAC_W]))
			+ ADJ_W'(sum_q[SUM_W-1] && (sum_q[FRAC_W-1:0] != '0));
		q_rate_k = (q_rate <<< 10) - (q_rate <<< 4) - (q_rate <<< 3);
		// auto: scaled sum over 2^32, truncated toward zero
		t_auto   = $signed(scaled_q[SCALED_W-1:FRAC_W])
			+ ADJ_W'(scaled_q[SCALED_W-1] && (scaled_q[FRAC_W-1:0] != '0));
		if (mode_q[MODE_RATE]) adj_c = scaled_q[ADJ_W-1:0];
		else begin
			priority if (t_auto > ADJ16_MAX) adj_c = ADJ16_MAX;
			else if (t_auto < ADJ16_MIN) adj_c = ADJ16_MIN;
			else adj_c = t_auto;
		end
	end

	// final servo value, clamp and integrator update
	always_comb begin
		base_c  = mode_q[MODE_RATE] ? stick_q : prev_servo_q;
		servo_c = $signed({{(SERVO_W-STICK_W){1'b0}}, base_c}) + SERVO_W'(adj_q);
		hi_c    = $signed({{(SERVO_W-STICK_W){1'b0}}, lim_hi_q});
		lo_c    = $signed({{(SERVO_W-STICK_W){1'b0}}, lim_lo_q});
		clamp_c = 1'b0;
		if (!mode_q[MODE_EN]) servo_sel = stick_q;
		else begin
			// ceiling first, so with crossed limits a value above the ceiling gives the ceiling
			priority if (servo_c > hi_c) begin
				servo_sel = lim_hi_q;
				clamp_c   = 1'b1;
			end else if (servo_c < lo_c) begin
				servo_sel = lim_lo_q;
				clamp_c   = 1'b1;
			end else begin
				servo_sel = servo_c[STICK_W-1:0];
			end
		end
		integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err_q);
		priority if (integ_sum > (INTEG_W+1)'(INTEG_MAX)) integ_c = INTEG_MAX;
		else if (integ_sum < (INTEG_W+1)'(INTEG_MIN)) integ_c = INTEG_MIN;
		else integ_c = integ_sum[INTEG_W-1:0];
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					stick_q  <= s_axis_tdata[STICK_W-1:0];
					rate_q   <= s_axis_tdata[STICK_W+RATE_W-1:STICK_W];
					avg_q    <= s_axis_tdata[S_DATA_W-1:STICK_W+RATE_W];
					offset_q <= offset_c;
					span_q   <= span_c;
				end
			end
			ST_MUL_TGT: prod_q <= mul_p;
			ST_DIV_LOAD: begin
				// zero span gives a zero target
				num_q  <= (span_q == '0) ? '0 : prod_mag[DIV_W-1:0];
				neg_q  <= prod_q[PROD_W-1] ^ span_q[OFS_W-1];
				dsor_q <= span_q[OFS_W-1] ? STICK_W'(-span_q) : span_q[STICK_W-1:0];
				rem_q  <= '0;
				cnt_q  <= '0;
				tgt_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= div_ge ? div_diff[STICK_W-1:0] : div_shift[STICK_W-1:0];
				num_q <= {num_q[DIV_W-2:0], div_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_TGT: tgt_q <= neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});
			ST_ERR: begin
				err_q   <= err_c;
				delta_q <= DELTA_W'(err_c) - DELTA_W'(prev_err_q);
			end
			ST_MUL_P: prod_q <= mul_p;
			ST_MUL_D: begin
				acc_q  <= prod_ext;
				prod_q <= mul_p;
			end
			ST_MUL_IL: begin
				acc_q  <= acc_q + prod_ext;
				prod_q <= mul_p;
			end
			ST_MUL_IH: begin
				acc_q  <= acc_q + prod_ext;
				prod_q <= mul_p;
			end
			// upper integral half carries a weight of 2^24
			ST_SUM:   acc_q <= acc_q + (prod_ext <<< INTEG_H);
			ST_CLIP:  sum_q <= sum_clip[SUM_W-1:0];
			ST_SCALE: begin
				if (mode_q[MODE_RATE]) scaled_q <= SCALED_W'(q_rate_k);
				else scaled_q <= (sum_ext <<< 10) - (sum_ext <<< 4) - (sum_ext <<< 3);
			end
			ST_ADJ:   adj_q <= mode_q[MODE_REV] ? -adj_c : adj_c;
			ST_DONE:  acc_q <= acc_q;
			default:  acc_q <= acc_q;
		endcase
	end

	// PID state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q   <= '0;
			integ_q      <= '0;
			prev_servo_q <= '0;
			out_valid_q  <= 1'b0;
			servo_q      <= '0;
			clamped_q    <= 1'b0;
		end else begin
			if (state_q == ST_ERR) prev_err_q <= err_c;
			if (out_load) begin
				out_valid_q  <= 1'b1;
				servo_q      <= servo_sel;
				clamped_q    <= clamp_c;
				prev_servo_q <= servo_sel;
				// anti-windup: integrate only when the output stayed in range
				if (mode_q[MODE_EN] && !clamp_c) integ_q <= integ_c;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	// one item in flight: an accepted word closes the input until it is done
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an update is in flight");

	// a clamped result sits on one of the limits
	a_clamp_on_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
			(m_axis_tdata == lim_hi_q || m_axis_tdata == lim_lo_q))
		else $error("clamp flag set but servo value off the limits");

	// a disabled axis passes the stick through unclamped
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !mode_q[MODE_EN]) |=>
			(servo_q == $past(stick_q) && !clamped_q))
		else $error("disabled axis did not pass the stick through");

	// divider step count stays inside the run
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)))
		else $error("divider ran past its last step");
`endif

endmodule

FILE: sim/servo_update_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo axis update checker
// Watches the configuration channel and both streams of the stabiliser core,
// works out every servo word from its own copy of the registers and PID state,
// and compares each output word with the oldest one still due.
// ----------------------------------------------------------------------------
module servo_update_checker
	import spsa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_axis_tdata,
	input  logic                s_axis_tvalid,
	input  logic                s_axis_tready,
	input  logic [M_DATA_W-1:0] m_axis_tdata,
	input  logic                m_axis_tuser,
	input  logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	output int                  fault_count,
	output int                  words_due
);

	localparam longint Q32       = longint'(1) << 32;
	localparam longint ITERM_CAP = longint'(1) << 60;
	localparam longint SUM_CAP   = longint'(1) << 40;
	localparam longint ERR_MAX   = (longint'(1) << (ERR_W - 1)) - 1;
	localparam longint ERR_MIN   = -(longint'(1) << (ERR_W - 1));
	localparam longint INTEG_MAX = (longint'(1) << (INTEG_W - 1)) - 1;
	localparam longint INTEG_MIN = -(longint'(1) << (INTEG_W - 1));
	localparam longint ADJ_MAX   = 32767;
	localparam longint ADJ_MIN   = -32768;
	localparam longint OUT_SCALE = 1000;

	typedef struct {
		logic [M_DATA_W-1:0] servo;
		logic                clamped;
	} servo_word_t;

	logic signed [GAIN_W-1:0] kp, ki, kd;
	logic [STICK_W-1:0]       center, limit_lo, limit_hi;
	logic [MAXT_W-1:0]        max_target;
	logic [MODE_W-1:0]        mode;

	longint              last_error;
	longint              error_integ;
	logic [M_DATA_W-1:0] last_servo;

	servo_word_t servo_words_due[$];
	servo_word_t want;
	int          faults;

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	// PID sum in Q.32; advances the stored error
	function automatic longint pid_sum_q32(input longint err);
		longint gp, gi, gd, delta, gi_mag, integ_mag, iterm, sum;
		gp = kp;
		gi = ki;
		gd = kd;
		delta = err - last_error;
		gi_mag = gi < 0 ? -gi : gi;
		integ_mag = error_integ < 0 ? -error_integ : error_integ;
		if (gi_mag != 0 && integ_mag > ITERM_CAP / gi_mag)
			iterm = ((gi < 0) != (error_integ < 0)) ? -ITERM_CAP : ITERM_CAP;
		else
			iterm = gi * error_integ;
		sum = gp * err + iterm + gd * delta;
		last_error = err;
		return clip(sum, -SUM_CAP, SUM_CAP);
	endfunction

	function automatic servo_word_t predict_servo(input logic [S_DATA_W-1:0] word);
		servo_word_t res;
		longint stick, rate, avg, ctr, lo, hi, maxt;
		longint offset, span, target, err, sum, adjust, base, servo;
		stick = word[STICK_W-1:0];
		rate  = $signed(word[STICK_W +: RATE_W]);
		avg   = $signed(word[STICK_W + RATE_W +: RATE_W]);
		ctr   = center;
		lo    = limit_lo;
		hi    = limit_hi;
		maxt  = max_target;
		res.clamped = 1'b0;
		if (!mode[MODE_EN]) begin
			servo = stick;
		end else begin
			if (mode[MODE_RATE]) begin
				err = clip(avg - rate, ERR_MIN, ERR_MAX);
				sum = pid_sum_q32(err);
				adjust = (sum / Q32) * OUT_SCALE;
				base = stick;
			end else begin
				offset = stick - ctr;
				span = offset < 0 ? ctr - lo : hi - ctr;
				// a zero span gives no target; a negative one divides as it stands
				target = (span == 0) ? 0 : (offset * maxt) / span;
				err = clip(target - rate, ERR_MIN, ERR_MAX);
				sum = pid_sum_q32(err);
				adjust = clip((sum * OUT_SCALE) / Q32, ADJ_MIN, ADJ_MAX);
				base = last_servo;
			end
			if (mode[MODE_REV])
				adjust = -adjust;
			servo = base + adjust;
			// ceiling first, so with crossed limits a value above the ceiling gives the ceiling
			if (servo > hi) begin
				servo = hi;
				res.clamped = 1'b1;
			end else if (servo < lo) begin
				servo = lo;
				res.clamped = 1'b1;
			end else begin
				error_integ = clip(error_integ + err, INTEG_MIN, INTEG_MAX);
			end
		end
		last_servo = servo[M_DATA_W-1:0];
		res.servo = last_servo;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			kd = '0;
			center = CENTER_RST;
			limit_lo = LIM_LO_RST;
			limit_hi = LIM_HI_RST;
			max_target = '0;
			mode = '0;
			last_error = 0;
			error_integ = 0;
			last_servo = '0;
			servo_words_due.delete();
			faults = 0;
			fault_count <= 0;
			words_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_GAIN_P:  kp = cfg_data[GAIN_W-1:0];
					REG_GAIN_I:  ki = cfg_data[GAIN_W-1:0];
					REG_GAIN_D:  kd = cfg_data[GAIN_W-1:0];
					REG_CENTER:  center = cfg_data[STICK_W-1:0];
					REG_LIM_LO:  limit_lo = cfg_data[STICK_W-1:0];
					REG_LIM_HI:  limit_hi = cfg_data[STICK_W-1:0];
					REG_MAX_TGT: max_target = cfg_data[MAXT_W-1:0];
					REG_MODE:    mode = cfg_data[MODE_W-1:0];
				endcase
			end
			// check the outgoing word before queueing a new one
			if (m_axis_tvalid && m_axis_tready) begin
				if (servo_words_due.size() == 0) begin
					$error("servo word with none due: servo_out %0d, was_clamped %0b",
						m_axis_tdata, m_axis_tuser);
					faults++;
				end else begin
					want = servo_words_due.pop_front();
					if (m_axis_tdata !== want.servo) begin
						$error("servo_out: expected %0d, got %0d", want.servo, m_axis_tdata);
						faults++;
					end
					if (m_axis_tuser !== want.clamped) begin
						$error("was_clamped: expected %0b, got %0b", want.clamped,
							m_axis_tuser);
						faults++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				servo_words_due.push_back(predict_servo(s_axis_tdata));
			fault_count <= faults;
			words_due <= servo_words_due.size();
		end
	end

endmodule

FILE: sim/servo_pid_stabilizer_axis_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo axis PID stabiliser core test
// Drives control updates through the core under a series of register
// settings: a short directed part for the extremes and special cases, then
// random settings and updates with idle bursts on both streams and one long
// receiver hold-off. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module servo_pid_stabilizer_axis_core_test;
	import spsa_pkg::*;

	localparam int CLK_HIGH          = 6;
	localparam int CLK_LOW           = 6;
	localparam int RESET_CYCLES      = 5;
	localparam int RANDOM_PHASES     = 12;
	localparam int UPDATES_PER_PHASE = 50;
	localparam int QUIET_PHASES      = 2;
	localparam int HOLD_CYCLES       = 300;
	localparam int DRAIN_CYCLES      = 70;
	localparam int WATCHDOG_LIMIT    = 3000;

	localparam logic [MODE_W-1:0] AXIS_ON   = 1 << MODE_EN;
	localparam logic [MODE_W-1:0] RATE_ONLY = 1 << MODE_RATE;
	localparam logic [MODE_W-1:0] REVERSED  = 1 << MODE_REV;

	typedef struct {
		logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
		logic [STICK_W-1:0]       center, limit_lo, limit_hi;
		logic [MAXT_W-1:0]        max_target;
		logic [MODE_W-1:0]        mode;
	} axis_settings_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                m_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]    cfg_data = '0;
	int                  fault_count;
	int                  words_due;

	bit hold_armed = 1'b0;
	bit quiet = 1'b0;
	int idle_cycles = 0;

	servo_pid_stabilizer_axis_core DUT (.*);

	servo_update_checker watcher (.*);

	always begin
		#CLK_LOW clk = 1'b1;
		#CLK_HIGH clk = 1'b0;
	end

	// give up once nothing has moved on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("servo_pid_stabilizer_axis_core test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall bursts, one long hold-off when armed, none when quiet
	initial begin
		bit held;
		int stall;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !held) begin
				held = 1'b1;
				stall = HOLD_CYCLES;
			end else if (quiet || $urandom_range(0, 4) != 0) begin
				stall = 0;
			end else begin
				stall = $urandom_range(1, 11);
			end
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// leave cfg_valid high; load_settings drops it after the last register
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_settings(input axis_settings_t cfg);
		write_reg(REG_GAIN_P, CFG_W'($unsigned(cfg.gain_p)));
		write_reg(REG_GAIN_I, CFG_W'($unsigned(cfg.gain_i)));
		write_reg(REG_GAIN_D, CFG_W'($unsigned(cfg.gain_d)));
		write_reg(REG_CENTER, CFG_W'(cfg.center));
		write_reg(REG_LIM_LO, CFG_W'(cfg.limit_lo));
		write_reg(REG_LIM_HI, CFG_W'(cfg.limit_hi));
		write_reg(REG_MAX_TGT, CFG_W'(cfg.max_target));
		write_reg(REG_MODE, CFG_W'(cfg.mode));
		cfg_valid <= 1'b0;
	endtask

	// offer one update word, optionally after an idle burst, and hold until taken
	task automatic offer_update(input logic [STICK_W-1:0] stick,
			input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] avg);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tdata <= {avg, rate, stick};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// drop valid and wait for every servo word still due, so the core is idle
	task automatic wait_for_servo_words();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic signed [GAIN_W-1:0] pick_gain();
		logic signed [GAIN_W-1:0] g;
		case ($urandom_range(0, 5))
			0: g = GAIN_W'($urandom);
			1: g = '0;
			default: g = GAIN_W'($urandom_range(0, 32'h0001_8000));
		endcase
		if ($urandom_range(0, 2) == 0)
			g = -g;
		return g;
	endfunction

	function automatic logic [RATE_W-1:0] pick_rate();
		logic [RATE_W-1:0] r;
		case ($urandom_range(0, 7))
			0: r = $urandom;
			1: r = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: r = $urandom_range(0, 32'h0003_FFFF);
		endcase
		if ($urandom_range(0, 1))
			r = -r;
		return r;
	endfunction

	function automatic axis_settings_t pick_settings();
		axis_settings_t cfg;
		cfg.gain_p = pick_gain();
		cfg.gain_i = pick_gain();
		cfg.gain_d = pick_gain();
		if ($urandom_range(0, 5) == 0) begin
			cfg.center = $urandom;
			cfg.limit_lo = $urandom;
			cfg.limit_hi = $urandom;
		end else begin
			cfg.limit_lo = $urandom_range(1000, 4000);
			cfg.limit_hi = $urandom_range(5000, 8000);
			cfg.center = $urandom_range(cfg.limit_lo, cfg.limit_hi);
		end
		case ($urandom_range(0, 3))
			0: cfg.max_target = MAXT_W'($urandom);
			1: cfg.max_target = '0;
			default: cfg.max_target = $urandom_range(0, 32'h0008_0000);
		endcase
		cfg.mode = MODE_W'($urandom);
		if ($urandom_range(0, 3) != 0)
			cfg.mode = cfg.mode | AXIS_ON;
		return cfg;
	endfunction

	task automatic run_random_phase();
		axis_settings_t cfg;
		logic [STICK_W-1:0] stick;
		logic [RATE_W-1:0] rate, avg, nudge;
		cfg = pick_settings();
		load_settings(cfg);
		for (int n = 0; n < UPDATES_PER_PHASE; n++) begin
			case ($urandom_range(0, 7))
				0: stick = $urandom;
				1: stick = cfg.center;
				2: stick = $urandom_range(0, 1) ? '1 : '0;
				default: stick = $urandom_range(cfg.limit_lo, cfg.limit_hi);
			endcase
			rate = pick_rate();
			// averaged rate mostly tracks the gyro, now and then anything at all
			if ($urandom_range(0, 3) == 0) begin
				avg = pick_rate();
			end else begin
				nudge = $urandom_range(0, 32'h0000_3FFF);
				if ($urandom_range(0, 1))
					nudge = -nudge;
				avg = rate + nudge;
			end
			offer_update(stick, rate, avg);
		end
		wait_for_servo_words();
	endtask

	initial begin
		axis_settings_t cfg;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings leave the axis off: stick passes straight through
		offer_update(16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		offer_update(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		wait_for_servo_words();

		// auto mode, usual limits: stick and rate extremes, centre and both ends
		cfg = '{gain_p: 24'h01_0000, gain_i: 24'h00_0100, gain_d: 24'h00_8000,
			center: 16'd4500, limit_lo: 16'd3000, limit_hi: 16'd6000,
			max_target: 31'd6553600, mode: AXIS_ON};
		load_settings(cfg);
		offer_update(16'd0, 32'h8000_0000, 32'd0);
		offer_update(16'hFFFF, 32'h7FFF_FFFF, 32'd0);
		offer_update(16'd4500, 32'd0, 32'd0);
		offer_update(16'd3000, 32'h0001_0000, 32'd0);
		offer_update(16'd6000, 32'hFFFF_0000, 32'd0);
		wait_for_servo_words();

		// rate-only, reversed, gains and limits at their extremes
		cfg = '{gain_p: 24'h7F_FFFF, gain_i: 24'h80_0000, gain_d: 24'h7F_FFFF,
			center: 16'h8000, limit_lo: 16'h0000, limit_hi: 16'hFFFF,
			max_target: 31'h7FFF_FFFF, mode: AXIS_ON | RATE_ONLY | REVERSED};
		load_settings(cfg);
		offer_update(16'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		offer_update(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
		offer_update(16'h1234, 32'h0000_1000, 32'h0000_1800);
		offer_update(16'hFFFF, 32'd0, 32'd0);
		wait_for_servo_words();

		// rate-only with modest gains: one clamped, one inside the limits
		cfg = '{gain_p: 24'h01_0000, gain_i: 24'h00_1000, gain_d: 24'h00_0800,
			center: 16'd4500, limit_lo: 16'd3000, limit_hi: 16'd6000,
			max_target: 31'd0, mode: AXIS_ON | RATE_ONLY};
		load_settings(cfg);
		offer_update(16'd4500, 32'h0001_0000, 32'h0003_0000);
		offer_update(16'd4500, 32'h0001_0000, 32'h0001_8000);
		wait_for_servo_words();

		// centre on the ceiling: zero span above it, reversed auto mode
		cfg = '{gain_p: 24'h02_0000, gain_i: 24'h00_0000, gain_d: 24'h00_1000,
			center: 16'd6000, limit_lo: 16'd3000, limit_hi: 16'd6000,
			max_target: 31'h0010_0000, mode: AXIS_ON | REVERSED};
		load_settings(cfg);
		offer_update(16'd6500, 32'h0000_4000, 32'd0);
		offer_update(16'hFFFF, 32'hFFFF_C000, 32'd0);
		offer_update(16'd5000, 32'd0, 32'd0);
		wait_for_servo_words();

		// crossed limits with the centre below both: negative span below the centre
		cfg = '{gain_p: 24'h00_4000, gain_i: 24'h00_0200, gain_d: 24'h00_0000,
			center: 16'd1000, limit_lo: 16'd6000, limit_hi: 16'd3000,
			max_target: 31'h0002_0000, mode: AXIS_ON};
		load_settings(cfg);
		offer_update(16'd500, 32'd0, 32'd0);
		offer_update(16'd8000, 32'h0000_2000, 32'd0);
		offer_update(16'd4500, 32'd0, 32'd0);
		wait_for_servo_words();

		// centre above the ceiling: negative span on the upper side
		cfg = '{gain_p: 24'h00_8000, gain_i: 24'h00_0100, gain_d: 24'h00_0400,
			center: 16'd7000, limit_lo: 16'd3000, limit_hi: 16'd6000,
			max_target: 31'h0004_0000, mode: AXIS_ON};
		load_settings(cfg);
		offer_update(16'd8000, 32'd0, 32'd0);
		offer_update(16'hFFFF, 32'h0000_8000, 32'd0);
		wait_for_servo_words();

		// random part; the receiver holds off once at its start, the tail runs flat out
		hold_armed <= 1'b1;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES - QUIET_PHASES)
				quiet <= 1'b1;
			run_random_phase();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("servo_pid_stabilizer_axis_core test passed");
		else
			$display("servo_pid_stabilizer_axis_core test failed");
		$finish;
	end

endmodule
